FILE: rtl/lca_pkg.sv
package lca_pkg;

	localparam int MAX_NODES   = 65536;
	localparam int NODE_W      = 16;
	localparam int ADDR_W      = $clog2(MAX_NODES);
	localparam int ENTRY_W     = 2 * NODE_W;
	localparam int STEP_W      = $clog2(MAX_NODES) + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLIMB,
		ST_MEET
	} state_t;

	// One queued transaction, already classified by the front end.
	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [NODE_W-1:0] parent;
		logic [NODE_W-1:0] depth;
		logic              a_ok;
		logic              b_ok;
	} item_t;

	function automatic logic in_table(input logic [NODE_W-1:0] n);
		return 32'(n) < MAX_NODES;
	endfunction

	function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
		return ADDR_W'(n);
	endfunction

endpackage

FILE: rtl/lca_front.sv
module lca_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         action,
	input  logic [lca_pkg::NODE_W-1:0]   first_node,
	input  logic [lca_pkg::NODE_W-1:0]   second_node,
	input  logic [lca_pkg::NODE_W-1:0]   parent_node,
	input  logic [lca_pkg::NODE_W-1:0]   node_depth,
	output logic                         q_valid,
	output lca_pkg::item_t               q_item,
	input  logic                         q_pop
);
	import lca_pkg::*;

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             new_item;
	logic              push;
	logic              pop;

	always_comb begin
		new_item.op     = op_t'(action);
		new_item.node_a = first_node;
		new_item.node_b = second_node;
		new_item.parent = parent_node;
		new_item.depth  = node_depth;
		new_item.a_ok   = in_table(first_node);
		new_item.b_ok   = in_table(second_node);
	end

	assign item_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/lca_back.sv
module lca_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  lca_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [lca_pkg::NODE_W-1:0]   ancestor
);
	import lca_pkg::*;

	logic [ENTRY_W-1:0] entry_mem_q [MAX_NODES];
	logic [ENTRY_W-1:0] rd_a_q;
	logic [ENTRY_W-1:0] rd_b_q;
	logic               zero_a_q;
	logic               zero_b_q;

	state_t             state_q, state_d;
	logic [NODE_W-1:0]  a_q, a_d;
	logic [NODE_W-1:0]  b_q, b_d;
	logic [NODE_W-1:0]  target_q, target_d;
	logic               climb_b_q, climb_b_d;
	logic [STEP_W-1:0]  steps_q, steps_d;
	logic               out_valid_q;
	logic [NODE_W-1:0]  ancestor_q;

	logic               we;
	logic               rd_a_en;
	logic               rd_b_en;
	logic [NODE_W-1:0]  rd_a_node;
	logic [NODE_W-1:0]  rd_b_node;
	logic               rd_a_ok;
	logic               rd_b_ok;
	logic [NODE_W-1:0]  par_a, dep_a, par_b, dep_b;
	logic [NODE_W-1:0]  cur_par, cur_dep;
	logic               res_load;
	logic [NODE_W-1:0]  res_val;
	logic               out_free;
	logic               budget_out;

	// A node outside the table reads as parent 0, depth 0.
	assign par_a = zero_a_q ? '0 : rd_a_q[ENTRY_W-1:NODE_W];
	assign dep_a = zero_a_q ? '0 : rd_a_q[NODE_W-1:0];
	assign par_b = zero_b_q ? '0 : rd_b_q[ENTRY_W-1:NODE_W];
	assign dep_b = zero_b_q ? '0 : rd_b_q[NODE_W-1:0];

	assign cur_par    = climb_b_q ? par_b : par_a;
	assign cur_dep    = climb_b_q ? dep_b : dep_a;
	assign out_free   = !out_valid_q || !result_stall;
	assign budget_out = (steps_q >= STEP_W'(MAX_NODES));

	assign result_valid = out_valid_q;
	assign ancestor     = ancestor_q;

	always_comb begin
		state_d   = state_q;
		a_d       = a_q;
		b_d       = b_q;
		target_d  = target_q;
		climb_b_d = climb_b_q;
		steps_d   = steps_q;
		q_pop     = 1'b0;
		we        = 1'b0;
		rd_a_en   = 1'b0;
		rd_b_en   = 1'b0;
		rd_a_node = q_item.node_a;
		rd_b_node = q_item.node_b;
		res_load  = 1'b0;
		res_val   = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.op == OP_QUERY) begin
						a_d     = q_item.node_a;
						b_d     = q_item.node_b;
						rd_a_en = 1'b1;
						rd_b_en = 1'b1;
						state_d = ST_LOAD;
					end else begin
						we = q_item.a_ok;
					end
				end
			end
			ST_LOAD: begin
				// The deeper node climbs; on equal depth the climb ends at once.
				climb_b_d = !(dep_a > dep_b);
				target_d  = (dep_a > dep_b) ? dep_b : dep_a;
				steps_d   = '0;
				state_d   = ST_CLIMB;
			end
			ST_CLIMB: begin
				if (cur_dep == target_q) begin
					steps_d = '0;
					state_d = ST_MEET;
				end else if (budget_out) begin
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					steps_d = steps_q + STEP_W'(1);
					if (climb_b_q) begin
						b_d       = cur_par;
						rd_b_node = cur_par;
						rd_b_en   = 1'b1;
					end else begin
						a_d       = cur_par;
						rd_a_node = cur_par;
						rd_a_en   = 1'b1;
					end
				end
			end
			ST_MEET: begin
				if (a_q == b_q) begin
					if (out_free) begin
						res_load = 1'b1;
						res_val  = a_q;
						state_d  = ST_IDLE;
					end
				end else if (budget_out) begin
					if (out_free) begin
						res_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					steps_d   = steps_q + STEP_W'(1);
					a_d       = par_a;
					b_d       = par_b;
					rd_a_node = par_a;
					rd_b_node = par_b;
					rd_a_en   = 1'b1;
					rd_b_en   = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_a_ok = in_table(rd_a_node);
	assign rd_b_ok = in_table(rd_b_node);

	always_ff @(posedge clk) begin
		if (we) begin
			entry_mem_q[node_addr(q_item.node_a)] <= {q_item.parent, q_item.depth};
		end
		if (rd_a_en) begin
			rd_a_q   <= entry_mem_q[rd_a_ok ? node_addr(rd_a_node) : '0];
			zero_a_q <= !rd_a_ok;
		end
		if (rd_b_en) begin
			rd_b_q   <= entry_mem_q[rd_b_ok ? node_addr(rd_b_node) : '0];
			zero_b_q <= !rd_b_ok;
		end
	end

	always_ff @(posedge clk) begin
		a_q       <= a_d;
		b_q       <= b_d;
		target_q  <= target_d;
		climb_b_q <= climb_b_d;
		steps_q   <= steps_d;
		if (res_load) begin
			ancestor_q <= res_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lowest_common_ancestor.sv
// Writes go through the climbing engine and give no result. A query reads both nodes'
// entries, climbs the deeper node up to the shallower depth, then climbs both together
// until they meet, each step one read of the parent/depth table; a four-entry queue
// lets writes and queries queue up.
// Reset (arst_n low, asynchronous) empties the queue and result register; the node
// table is not cleared and holds unknown data until written.
module lowest_common_ancestor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         action,
	input  logic [lca_pkg::NODE_W-1:0]   first_node,
	input  logic [lca_pkg::NODE_W-1:0]   second_node,
	input  logic [lca_pkg::NODE_W-1:0]   parent_node,
	input  logic [lca_pkg::NODE_W-1:0]   node_depth,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [lca_pkg::NODE_W-1:0]   ancestor
);
	import lca_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	lca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.first_node  (first_node),
		.second_node (second_node),
		.parent_node (parent_node),
		.node_depth  (node_depth),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	lca_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ancestor     (ancestor)
	);

endmodule
